// ----- sv/fed_pkg.sv -----
package fed_pkg;

    // Fixed field widths of the configuration registers.
    localparam int LEVEL_BITS    = 16;
    localparam int RING_BITS     = 17;
    localparam int CFG_DATA_BITS = 17;
    localparam int CFG_IDX_BITS  = 2;

    // Q1.15 arithmetic constants.
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_HALF = 16384;
    localparam logic [LEVEL_BITS-1:0] UNITY = 16'h8000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MIX_LEVEL     = 2'd0,
        REG_RING_LENGTH   = 2'd1,
        REG_DELAY_SAMPLES = 2'd2,
        REG_ENABLE        = 2'd3
    } fed_reg_t;

    // Per-item control flags that travel down the pipeline.
    typedef struct packed {
        logic active;   // echo path: store is read and updated
        logic hit;      // echo read address equals this item's write address
        logic mute;     // bypass item that yields zero (silent while enabled)
    } fed_flags_t;

endpackage

// ----- sv/fed_ram.sv -----
module fed_ram #(
    parameter int STORE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          store_ready,
    input  logic                          rd_en,
    input  logic [ADDR_BITS-1:0]          rd_addr,
    output logic signed [SAMPLE_BITS-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_BITS-1:0]          wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data
);
    import fed_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } fed_ram_state_t;

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(STORE_DEPTH - 1);

    logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
    fed_ram_state_t                state_reg;
    fed_ram_state_t                state_next;
    logic [ADDR_BITS-1:0]          clr_addr_reg;
    logic                          clearing;

    assign clearing    = (state_reg == ST_CLEAR);
    assign store_ready = (state_reg == ST_RUN);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // The sweep zeroes one entry per cycle after reset.
    always_ff @(posedge aclk) begin
        if (clearing) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/fed_index.sv -----
module fed_index #(
    parameter int STORE_DEPTH = 65536,
    parameter int ADDR_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [fed_pkg::RING_BITS-1:0]  ring_length,
    input  logic [fed_pkg::RING_BITS-1:0]  delay_samples,
    output logic [ADDR_BITS-1:0]           wr_addr,
    output logic [ADDR_BITS-1:0]           rd_addr,
    output logic                           hit
);
    import fed_pkg::*;

    localparam int CNT_BITS = ADDR_BITS + 1;
    localparam int LW       = (CNT_BITS > RING_BITS) ? CNT_BITS : RING_BITS;
    localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);
    localparam logic [LW-1:0] ONE_L   = LW'(1);

    logic [ADDR_BITS-1:0] wi_reg;
    logic [LW-1:0]        ring_l;
    logic [LW-1:0        ] dly_l;
    logic [LW-1:0]        len;
    logic [LW-1:0]        dly;
    logic [LW-1:0]        wi_inc;
    logic [LW-1:0]        wi_new;
    logic [LW-1:0]        rd_full;

    always_comb begin
        ring_l = LW'(ring_length);
        dly_l  = LW'(delay_samples);
        if (ring_l == '0) begin
            len = ONE_L;
        end else if (ring_l > DEPTH_L) begin
            len = DEPTH_L;
        end else begin
            len = ring_l;
        end
        dly    = (dly_l > len) ? len : dly_l;
        wi_inc = LW'(wi_reg) + ONE_L;
        wi_new = (wi_inc >= len) ? '0 : wi_inc;
        if (wi_new < dly) begin
            rd_full = wi_new + len - dly;
        end else begin
            rd_full = wi_new - dly;
        end
    end

    assign wr_addr = wi_reg;
    assign rd_addr = rd_full[ADDR_BITS-1:0];
    assign hit     = (rd_full[ADDR_BITS-1:0] == wi_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg <= '0;
        end else if (step) begin
            wi_reg <= wi_new[ADDR_BITS-1:0];
        end
    end

endmodule

// ----- sv/fed_mix.sv -----
module fed_mix #(
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic signed [SAMPLE_BITS-1:0]   in_x,
    input  logic [fed_pkg::LEVEL_BITS-1:0]  in_level,
    input  fed_pkg::fed_flags_t             in_flags,
    input  logic [ADDR_BITS-1:0]            in_waddr,
    input  logic signed [SAMPLE_BITS-1:0]   rd_data,
    output logic                            s1_busy,
    output logic                            wr_en,
    output logic [ADDR_BITS-1:0]            wr_addr,
    output logic signed [SAMPLE_BITS-1:0]   wr_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]   m_out_sample
);
    import fed_pkg::*;

    localparam int FW = SAMPLE_BITS + 19;
    localparam logic signed [FW-1:0] HALF_F = FW'(ROUND_HALF);
    localparam logic signed [FW-1:0] SMAX =
        {{(FW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [FW-1:0] SMIN =
        {{(FW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [FW-1:0] v
    );
        logic signed [FW-1:0] q;
        q = (v + HALF_F) >>> FRAC_BITS;
        if (q > SMAX) begin
            q = SMAX;
        end else if (q < SMIN) begin
            q = SMIN;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    // Stage 1: feedback write.
    logic                          s1_valid_reg;
    fed_flags_t                    s1_flags_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [LEVEL_BITS-1:0]         s1_level_reg;
    logic [ADDR_BITS-1:0]          s1_waddr_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    // Stage 2: output mix.
    logic                          s2_valid_reg;
    fed_flags_t                    s2_flags_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x_reg;
    logic [LEVEL_BITS-1:0]         s2_level_reg;
    logic signed [SAMPLE_BITS-1:0] s2_b_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    logic                          s1_move;
    logic                          s2_move;
    logic                          s2_free;
    logic signed [LEVEL_BITS:0]    level1_s;
    logic signed [LEVEL_BITS:0]    level2_s;
    logic signed [SAMPLE_BITS+16:0] fb_prod;
    logic signed [FW-1:0]          fb_sum;
    logic signed [SAMPLE_BITS-1:0] fb_sat;
    logic signed [SAMPLE_BITS-1:0] echo_b;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [SAMPLE_BITS+17:0] mix_prod;
    logic signed [FW-1:0]          mix_sum;
    logic signed [SAMPLE_BITS-1:0] s2_result;

    assign s2_move = s2_valid_reg && (!out_valid_reg || m_ready);
    assign s2_free = !s2_valid_reg || s2_move;
    assign s1_move = s1_valid_reg && s2_free;
    assign s1_busy = s1_valid_reg;

    // fed = x * 1.0 + level * a
    assign level1_s = signed'({1'b0, s1_level_reg});
    assign fb_prod  = level1_s * a_reg;
    assign fb_sum   = (FW'(s1_x_reg) <<< FRAC_BITS) + FW'(fb_prod);
    assign fb_sat   = round_sat(fb_sum);
    // A read of the entry being written sees the new value.
    assign echo_b   = s1_flags_reg.hit ? fb_sat : rd_data;

    assign wr_en   = s1_move && s1_flags_reg.active;
    assign wr_addr = s1_waddr_reg;
    assign wr_data = fb_sat;

    // out = level * b + (1 - level) * x = level * (b - x) + x * 1.0
    assign level2_s = signed'({1'b0, s2_level_reg});
    assign diff     = (SAMPLE_BITS+1)'(s2_b_reg) - (SAMPLE_BITS+1)'(s2_x_reg);
    assign mix_prod = level2_s * diff;
    assign mix_sum  = (FW'(s2_x_reg) <<< FRAC_BITS) + FW'(mix_prod);

    always_comb begin
        if (s2_flags_reg.active) begin
            s2_result = round_sat(mix_sum);
        end else if (s2_flags_reg.mute) begin
            s2_result = '0;
        end else begin
            s2_result = s2_x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
        end else begin
            if (load) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_move) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (s1_move && s1_flags_reg.active) begin
                a_reg <= echo_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_flags_reg <= in_flags;
            s1_x_reg     <= in_x;
            s1_level_reg <= in_level;
            s1_waddr_reg <= in_waddr;
        end
        if (s1_move) begin
            s2_flags_reg <= s1_flags_reg;
            s2_x_reg     <= s1_x_reg;
            s2_level_reg <= s1_level_reg;
            s2_b_reg     <= echo_b;
        end
        if (s2_move) begin
            out_sample_reg <= s2_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_sample_reg;

endmodule

// ----- sv/feedback_echo_delay_top.sv -----
// Channel  | Ports                                  | Direction | Transfer when
// ---------+----------------------------------------+-----------+-----------------------
// input    | s_valid, s_ready, s_in_sample, s_silent | in        | s_valid && s_ready
// result   | m_valid, m_ready, m_out_sample          | out       | m_valid && m_ready
// config   | cfg_wr_en, cfg_index, cfg_data          | in        | cfg_wr_en
//
// A sample is not accepted while the previous one still sits in the feedback stage;
// the store write and the echo feedback of one sample settle in the stage after
// acceptance, ahead of the next read. m_valid rises when a sample's result, after the
// feedback and output mix stages, is registered; it transfers while m_ready is high.
// After reset the store is cleared one entry per cycle, and s_ready stays low until
// the sweep ends; configuration writes are taken meanwhile.
// A stalled output holds the two mix stages and then the input side; nothing is dropped.
module feedback_echo_delay_top #(
    parameter int STORE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_in_sample,
    input  logic                                s_silent,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_out_sample,
    input  logic                                cfg_wr_en,
    input  logic [fed_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fed_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import fed_pkg::*;

    localparam int ADDR_BITS = $clog2(STORE_DEPTH);

    // Configuration registers.
    logic [LEVEL_BITS-1:0] mix_level_reg;
    logic [RING_BITS-1:0]  ring_length_reg;
    logic [RING_BITS-1:0]  delay_samples_reg;
    logic                  enable_reg;

    logic                          store_ready;
    logic                          s1_busy;
    logic                          accept;
    logic                          step;
    logic [LEVEL_BITS-1:0]         level;
    fed_flags_t                    flags;
    logic [ADDR_BITS-1:0]          idx_wr_addr;
    logic [ADDR_BITS-1:0]          idx_rd_addr;
    logic                          idx_hit;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic                          mem_we;
    logic [ADDR_BITS-1:0]          mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_level_reg     <= LEVEL_BITS'(16384);
            ring_length_reg   <= RING_BITS'(48000);
            delay_samples_reg <= RING_BITS'(24000);
            enable_reg        <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (fed_reg_t'(cfg_index))
                REG_MIX_LEVEL:     mix_level_reg     <= cfg_data[LEVEL_BITS-1:0];
                REG_RING_LENGTH:   ring_length_reg   <= cfg_data[RING_BITS-1:0];
                REG_DELAY_SAMPLES: delay_samples_reg <= cfg_data[RING_BITS-1:0];
                REG_ENABLE:        enable_reg        <= cfg_data[0];
                default:           enable_reg        <= enable_reg;
            endcase
        end
    end

    // One sample may sit in the feedback stage at a time; the next one is taken
    // once it moves on, so a read never meets a pending write of an earlier sample.
    assign s_ready = store_ready && !s1_busy;
    assign accept  = s_valid && s_ready;

    // Levels above unity are clamped to 1.0.
    assign level = (mix_level_reg > UNITY) ? UNITY : mix_level_reg;

    // Only enabled, non-silent samples touch the store and the indexes.
    always_comb begin
        flags.active = enable_reg && !s_silent;
        flags.hit    = idx_hit;
        flags.mute   = enable_reg;
    end

    assign step = accept && flags.active;

    fed_index #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_index (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .ring_length   (ring_length_reg),
        .delay_samples (delay_samples_reg),
        .wr_addr       (idx_wr_addr),
        .rd_addr       (idx_rd_addr),
        .hit           (idx_hit)
    );

    // The echo read for a sample is issued in the same cycle as its input transfer.
    fed_ram #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_ram (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .store_ready (store_ready),
        .rd_en       (step),
        .rd_addr     (idx_rd_addr),
        .rd_data     (rd_data),
        .wr_en       (mem_we),
        .wr_addr     (mem_waddr),
        .wr_data     (mem_wdata)
    );

    // The mix unit keeps the previous echo read, which is the entry at the previous
    // sample's read index, so the feedback term needs no second store read.
    fed_mix #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_mix (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept),
        .in_x         (s_in_sample),
        .in_level     (level),
        .in_flags     (flags),
        .in_waddr     (idx_wr_addr),
        .rd_data      (rd_data),
        .s1_busy      (s1_busy),
        .wr_en        (mem_we),
        .wr_addr      (mem_waddr),
        .wr_data      (mem_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample)
    );

    // No input transfer follows another in the very next cycle.
    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input transfers in consecutive cycles");

    // A store read and a store write never fall on the same edge.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step && mem_we))
        else $error("store read and write overlap");

    // Nothing is written to the store while the clearing sweep runs.
    a_no_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> store_ready)
        else $error("store write during clearing sweep");

    // An echo read always leaves its sample in the feedback stage, where its store write follows.
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> s1_busy)
        else $error("feedback stage empty after an echo read");

endmodule
